/* src/swm_pkg.sv */
`timescale 1ns / 1ps

package swm_pkg;

  // Default number of cells in the window chain.
  localparam int unsigned WINDOW_DEPTH = 64;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register indexes (byte address = 4 * index).
  localparam logic REG_WINDOW_SIZE = 1'b0;

  localparam logic [SIZE_W-1:0] WINDOW_SIZE_RESET = 7'd3;

  typedef logic signed [DATA_W-1:0] sample_t;

endpackage

/* src/sliding_window_maximum_unit.sv */
`timescale 1ns / 1ps

// Channel | Handshake                     | Payload
// --------+-------------------------------+-------------------------
// in      | in_valid_i / in_stall_o       | sample_i, restart_i
// out     | out_valid_o / out_stall_i     | window_max_o
// cfg     | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// One request per cycle is accepted while in_stall_o is low; its result (if
// any) is registered in the output register, or in the skid entry while a
// stalled consumer holds the output register. The cell chain updates on that edge.
// Reset clears control only: fill count zero, window_size = 3, no result.
// in_stall_o rises only once the output register and its skid entry are
// both full, i.e. after two results wait behind a stalled consumer.
module sliding_window_maximum_unit #(
  parameter int unsigned WINDOW_DEPTH = swm_pkg::WINDOW_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            sample_i,
  input  logic                          restart_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            window_max_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swm_pkg::ADDR_W-1:0]    paddr,
  input  logic [swm_pkg::PDATA_W-1:0]   pwdata,
  output logic [swm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  // Fill count and effective size must hold WINDOW_DEPTH itself.
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  // Cell index width.
  localparam int unsigned IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [FW-1:0] DEPTH_F = FW'(WINDOW_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [swm_pkg::SIZE_W-1:0] window_size_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[2] == swm_pkg::REG_WINDOW_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= swm_pkg::WINDOW_SIZE_RESET;
    end else if (cfg_wr) begin
      window_size_q <= pwdata[swm_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == swm_pkg::REG_WINDOW_SIZE) begin
      prdata[swm_pkg::SIZE_W-1:0] = window_size_q;
    end
  end

  // Effective window: zero acts as one, oversize clamps to the chain length.
  logic [FW-1:0] win_k;

  always_comb begin
    if (window_size_q == '0) begin
      win_k = FW'(1);
    end else if (32'(window_size_q) > 32'(WINDOW_DEPTH)) begin
      win_k = DEPTH_F;
    end else begin
      win_k = FW'(window_size_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Fill tracking. An empty window (after reset or a size write) or a
  // restart_i on the sample makes that sample start a fresh prefix in every cell.
  // ---------------------------------------------------------------------------
  logic          in_acc;
  logic          obuf_full;
  logic [FW-1:0] fill_q, fill_d;
  logic          clear;

  assign in_stall_o = obuf_full;
  assign in_acc     = in_valid_i && !obuf_full;
  assign clear      = restart_i || (fill_q == '0);

  always_comb begin
    if (clear) begin
      fill_d = FW'(1);
    end else if (fill_q == DEPTH_F) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cfg_wr) begin
      fill_q <= '0;
    end else if (in_acc) begin
      fill_q <= fill_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: cell i holds the max over the newest i+1 samples since the
  // window was last emptied. Cell 0 simply holds the newest sample.
  // ---------------------------------------------------------------------------
  swm_pkg::sample_t cell_max [WINDOW_DEPTH];

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    swm_pkg::sample_t prev;
    if (i == 0) begin : g_head
      assign prev = sample_i;
    end else begin : g_link
      assign prev = cell_max[i-1];
    end

    swm_cell u_cell (
      .clk_i      (clk_i),
      .en_i       (in_acc),
      .clear_i    (clear),
      .sample_i   (sample_i),
      .prev_max_i (prev),
      .max_o      (cell_max[i])
    );
  end

  // Result = new value of cell k-1 = max(sample, old cell k-2).
  logic [FW-1:0]    k_m2;
  logic [IW-1:0]    tap_idx;
  swm_pkg::sample_t tap;
  swm_pkg::sample_t result;
  logic             push;

  assign k_m2    = win_k - FW'(2);
  assign tap_idx = k_m2[IW-1:0];
  assign tap     = cell_max[tap_idx];

  always_comb begin
    if (clear || (win_k == FW'(1)) || (sample_i > tap)) begin
      result = sample_i;
    end else begin
      result = tap;
    end
  end

  assign push = in_acc && (fill_d >= win_k);

  swm_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (result),
    .full_o      (obuf_full),
    .out_valid_o (out_valid_o),
    .out_data_o  (window_max_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  // Skid entry only fills behind a stalled output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid holds a result while output register is empty");

  // Fill count never passes the chain length.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_F)
    else $error("fill count beyond window depth");

  // A size write empties the window.
  a_cfg_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (fill_q == '0))
    else $error("window not emptied by size write");

  // A restart with a window wider than one gives no result.
  a_restart_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && restart_i && (win_k != FW'(1))) |-> !push)
    else $error("result produced on restart before window filled");
`endif

endmodule

/* src/swm_cell.sv */
`timescale 1ns / 1ps

// One window cell: holds the max over the newest i+1 samples.
// On a shift it takes max(new sample, neighbor's prefix max), or the sample alone on clear.
module swm_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              clear_i,
  input  swm_pkg::sample_t  sample_i,
  input  swm_pkg::sample_t  prev_max_i,
  output swm_pkg::sample_t  max_o
);

  swm_pkg::sample_t max_q;
  swm_pkg::sample_t max_d;

  always_comb begin
    if (clear_i || (sample_i > prev_max_i)) begin
      max_d = sample_i;
    end else begin
      max_d = prev_max_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      max_q <= max_d;
    end
  end

  assign max_o = max_q;

endmodule

/* src/swm_obuf.sv */
`timescale 1ns / 1ps

// Output register plus one skid entry; stalls upstream only when the skid is full.
module swm_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  swm_pkg::sample_t  data_i,
  output logic              full_o,
  output logic              out_valid_o,
  output swm_pkg::sample_t  out_data_o,
  input  logic              out_stall_i
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  swm_pkg::sample_t out_data_q, out_data_d;
  swm_pkg::sample_t skid_data_q, skid_data_d;
  logic             out_fire;

  assign out_fire = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_d = push_i;
      if (push_i) begin
        out_data_d = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* verif/window_max_checker.sv */
`timescale 1ns / 1ps

module window_max_checker #(
  parameter int unsigned WINDOW_DEPTH = swm_pkg::WINDOW_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic signed [31:0]           sample_i,
  input  logic                         restart_i,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic signed [31:0]           window_max_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [swm_pkg::ADDR_W-1:0]   paddr,
  input  logic [swm_pkg::PDATA_W-1:0]  pwdata,
  output int unsigned                  errors_o,
  output int unsigned                  pending_o
);

  localparam logic [swm_pkg::ADDR_W-1:0] SIZE_ADDR = {swm_pkg::REG_WINDOW_SIZE, 2'b00};
  localparam swm_pkg::sample_t MOST_NEG = {1'b1, {(swm_pkg::DATA_W-1){1'b0}}};

  swm_pkg::sample_t             window_q [WINDOW_DEPTH];
  int unsigned                  head_q;
  int unsigned                  fill_q;
  logic [swm_pkg::SIZE_W-1:0]   size_q;
  swm_pkg::sample_t             expected_max_q [$];

  task automatic clear_window();
    fill_q = 0;
    head_q = 0;
  endtask

  task automatic take_sample(input swm_pkg::sample_t s, input logic r);
    int unsigned      span;
    int unsigned      slot;
    swm_pkg::sample_t best;
    span = (size_q == 0) ? 1 : ((size_q > WINDOW_DEPTH) ? WINDOW_DEPTH : size_q);
    if (r) clear_window();
    window_q[head_q] = s;
    head_q = (head_q + 1) % WINDOW_DEPTH;
    if (fill_q < WINDOW_DEPTH) fill_q++;
    if (fill_q >= span) begin
      best = MOST_NEG;
      for (int i = 0; i < span; i++) begin
        slot = (head_q + 2 * WINDOW_DEPTH - 1 - i) % WINDOW_DEPTH;
        if (window_q[slot] > best) best = window_q[slot];
      end
      expected_max_q = {expected_max_q, best};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q = swm_pkg::WINDOW_SIZE_RESET;
      clear_window();
      expected_max_q.delete();
      errors_o = 0;
    end else begin
      // result side first: its expectation is always older than this edge's request
      if (out_valid_o && !out_stall_i) begin
        if (expected_max_q.size() == 0) begin
          $error("window_max: expected none, got %0d", window_max_o);
          errors_o++;
        end else begin
          if (window_max_o !== expected_max_q[0]) begin
            $error("window_max: expected %0d, got %0d", expected_max_q[0], window_max_o);
            errors_o++;
          end
          expected_max_q.delete(0);
        end
      end
      if (psel && penable && pwrite && pready && paddr == SIZE_ADDR) begin
        size_q = pwdata[swm_pkg::SIZE_W-1:0];
        clear_window();
      end
      if (in_valid_i && !in_stall_o) take_sample(sample_i, restart_i);
    end
    pending_o = expected_max_q.size();
  end

endmodule

/* verif/sliding_window_maximum_unit_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the sliding window maximum unit. The checker beside
// the DUT predicts every window maximum and compares; this module only makes
// traffic on the three ports and decides pass/fail.
module sliding_window_maximum_unit_tb;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned LONG_HOLD      = 200;
  localparam logic [swm_pkg::ADDR_W-1:0] SIZE_ADDR   = {swm_pkg::REG_WINDOW_SIZE, 2'b00};
  localparam logic [swm_pkg::ADDR_W-1:0] UNUSED_ADDR = 3'd4;  // register index 1, not mapped
  localparam int NO_SIZE_WRITE = -1;
  localparam swm_pkg::sample_t MAX_SAMPLE = 32'sh7fff_ffff;
  localparam swm_pkg::sample_t MIN_SAMPLE = 32'sh8000_0000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  swm_pkg::sample_t             sample_i;
  logic                         restart_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  swm_pkg::sample_t             window_max_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [swm_pkg::ADDR_W-1:0]   paddr;
  logic [swm_pkg::PDATA_W-1:0]  pwdata;
  logic [swm_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  int unsigned         errors;
  int unsigned         pending;
  bit                  no_idle = 1'b0;  // both sides run back to back while set

  always #6 clk_i = ~clk_i;

  sliding_window_maximum_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .window_max_o (window_max_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  window_max_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .window_max_o (window_max_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // Offer one sample after a random gap; returns at the edge that takes it.
  // Valid is left high so the next request can follow without a bubble.
  task automatic push_sample(input swm_pkg::sample_t s, input logic r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      sample_i   <= $urandom();  // junk while idle, must be ignored
      restart_i  <= $urandom_range(0, 1);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    restart_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering and let every predicted maximum come out before anything
  // touches the register port.
  task automatic settle_window();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [swm_pkg::ADDR_W-1:0] addr,
                            input logic [swm_pkg::PDATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mix of full-range values, a narrow band that produces ties, and the rails.
  function automatic swm_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom();
      5, 6:          return $signed($urandom_range(0, 6)) - 3;
      7:             return MAX_SAMPLE;
      8:             return MIN_SAMPLE;
      default:       return ($urandom_range(0, 1) ? MAX_SAMPLE : MIN_SAMPLE)
                            + $signed($urandom_range(0, 3)) - 1;
    endcase
  endfunction

  // Receiver: random stall per result, plus two long hold-offs so the DUT
  // backs up into its input while the sender keeps offering.
  initial begin : result_sink
    int unsigned taken;
    int unsigned w;
    taken       = 0;
    out_stall_i = 1'b0;
    forever begin
      if (taken == 100 || taken == 1200) begin
        repeat (LONG_HOLD) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      w = no_idle ? 0 : $urandom_range(0, 7);
      repeat (w) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // Watchdog: any cycle without a single handshake counts toward the limit.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("** sliding_window_maximum_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    swm_pkg::sample_t dir_samples [21];
    bit               dir_restart [21];
    int               phase_sizes [15];
    int               span;
    int unsigned      n_items;
    int unsigned      restart_odds;
    int               cur_size;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    sample_i   = '0;
    restart_i  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset window of 3: rails, a maximum at the rail
    // leaving the window, ties, a unique maximum leaving, restarts before
    // the window fills, and a restart on a fresh run of maxima.
    dir_samples = '{MAX_SAMPLE, MIN_SAMPLE, MIN_SAMPLE, MIN_SAMPLE,
                    5, 5, 5, 9, 1, 2, 3,
                    7, 6, -1, 0, -2, -3, -4,
                    MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE};
    dir_restart = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                    1, 0, 1, 0, 0, 0, 0, 1, 0, 0};
    for (int i = 0; i < 21; i++) push_sample(dir_samples[i], dir_restart[i]);
    settle_window();

    // Window sizes per phase: the extremes (zero, one, full depth, above depth,
    // all-ones), small ones for most traffic, and one phase that writes only
    // an unmapped address so the window must carry over untouched.
    phase_sizes = '{1, 2, 64, 0, 5, NO_SIZE_WRITE, 127, 3, 65, 8,
                    int'($urandom_range(1, 12)), 4, 7, int'($urandom_range(13, 40)), 1};
    cur_size = int'(swm_pkg::WINDOW_SIZE_RESET);

    for (int ph = 0; ph < 15; ph++) begin
      no_idle = (ph % 4 == 3);
      if (phase_sizes[ph] == NO_SIZE_WRITE) begin
        apb_access(1'b1, UNUSED_ADDR, $urandom());
        apb_access(1'b0, SIZE_ADDR, $urandom());  // read must not disturb anything
      end else begin
        cur_size = phase_sizes[ph];
        apb_access(1'b1, SIZE_ADDR,
                   (swm_pkg::PDATA_W'($urandom()) & ~swm_pkg::PDATA_W'(7'h7f)) |
                   swm_pkg::PDATA_W'(cur_size[6:0]));
      end
      span = (cur_size == 0) ? 1 : ((cur_size > 64) ? 64 : cur_size);
      // big windows: long runs with rare restarts so results keep coming
      n_items      = (span >= 32) ? 160 : 130;
      restart_odds = (span >= 32) ? 400 : 25;
      for (int i = 0; i < n_items; i++) begin
        if (ph == 4 && i == n_items / 2) settle_window();  // sender drains mid-phase
        push_sample(pick_sample(), $urandom_range(1, restart_odds) == 1);
      end
      settle_window();
    end

    no_idle = 1'b0;
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("** sliding_window_maximum_unit: PASSED **");
    end else begin
      $display("** sliding_window_maximum_unit: FAILED **");
    end
    $finish;
  end

endmodule
